@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked at every clock edge outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cau_pkg.sv @@
package cau_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DW = 16;
  // products of two 16-bit values, and sums of two of them
  localparam int PW = 33;
  // numerator after scaling and rounding room
  localparam int NW = PW + FRAC_BITS + 1;
  // quotient bits produced by the divide chain
  localparam int QW = 18 + FRAC_BITS;
  // root bits: sqrt of a 33-bit value
  localparam int RW = 17;
  // cells in the chain; quotient needs one bit per cell
  localparam int NCELL = QW;
  localparam int RPC = (RW + NCELL - 1) / NCELL;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MAG = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] res_re;
    logic signed [15:0] res_im;
    logic               overflow;
    logic               divide_by_zero;
  } out_word_t;

  // word traveling along the chain of cells
  typedef struct packed {
    logic              vld;
    logic [2:0]        op;
    logic              dz;
    logic              neg_re;
    logic              neg_im;
    logic [NW-1:0]     rem_re;   // partial remainders
    logic [NW-1:0]     rem_im;
    logic [NW-1:0]     den;      // divisor (den) or unused
    logic [QW-1:0]     q_re;     // quotient bits so far
    logic [QW-1:0]     q_im;
    logic [PW:0]       rs;       // root remainder
    logic [RW-1:0]     rr;       // root so far
    logic signed [PW:0] dir_re;  // direct results for add/sub/mul
    logic signed [PW:0] dir_im;
  } chain_t;

  function automatic logic signed [15:0] sat16(input logic signed [NW:0] v,
                                                output logic ovf);
    begin
      ovf = 1'b0;
      if (v > 32767) begin
        ovf = 1'b1;
        sat16 = 16'sh7fff;
      end else if (v < -32768) begin
        ovf = 1'b1;
        sat16 = -16'sh8000;
      end else begin
        sat16 = v[15:0];
      end
    end
  endfunction

endpackage

@@ hdl/cau_front.sv @@
module cau_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               vld_in,
  input  cau_pkg::in_word_t  word_in,
  output cau_pkg::chain_t    word_out
);
  import cau_pkg::*;

  // stage 1: four products
  logic               v1;
  logic [2:0]         op1;
  logic signed [15:0] ar1, ai1, br1, bi1;
  logic signed [31:0] p_rr, p_ii, p_ri, p_ir;
  // stage 2: sums
  chain_t w;
  logic signed [PW-1:0] nre, nim, den_s;
  logic signed [PW:0]   rnd_re, rnd_im;
  logic [NW-1:0]        mag_re, mag_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= vld_in;
    end
    op1  <= word_in.operation;
    ar1  <= word_in.a_re;
    ai1  <= word_in.a_im;
    br1  <= word_in.b_re;
    bi1  <= word_in.b_im;
    case (op_t'(word_in.operation))
      OP_MAG: begin
        p_rr <= word_in.a_re * word_in.a_re;
        p_ii <= word_in.a_im * word_in.a_im;
        p_ri <= '0;
        p_ir <= '0;
      end
      OP_DIV: begin
        p_rr <= word_in.a_re * word_in.b_re;
        p_ii <= word_in.a_im * word_in.b_im;
        p_ri <= word_in.a_im * word_in.b_re;
        p_ir <= word_in.a_re * word_in.b_im;
      end
      default: begin
        p_rr <= word_in.a_re * word_in.b_re;
        p_ii <= word_in.a_im * word_in.b_im;
        p_ri <= word_in.a_re * word_in.b_im;
        p_ir <= word_in.a_im * word_in.b_re;
      end
    endcase
  end

  // divisor squares share stage 1 timing through a second multiplier pair
  logic signed [31:0] d_rr, d_ii;
  always_ff @(posedge clk) begin
    d_rr <= word_in.b_re * word_in.b_re;
    d_ii <= word_in.b_im * word_in.b_im;
  end

  always_comb begin
    w = '0;
    w.vld = v1;
    w.op  = op1;
    rnd_re = '0;
    rnd_im = '0;
    den_s = PW'(d_rr) + PW'(d_ii);
    case (op_t'(op1))
      OP_ADD: begin
        w.dir_re = (PW+1)'(ar1) + (PW+1)'(br1);
        w.dir_im = (PW+1)'(ai1) + (PW+1)'(bi1);
      end
      OP_SUB: begin
        w.dir_re = (PW+1)'(ar1) - (PW+1)'(br1);
        w.dir_im = (PW+1)'(ai1) - (PW+1)'(bi1);
      end
      OP_MUL: begin
        rnd_re = (PW+1)'(p_rr) - (PW+1)'(p_ii) + (PW+1)'(1 << (FRAC_BITS - 1));
        rnd_im = (PW+1)'(p_ri) + (PW+1)'(p_ir) + (PW+1)'(1 << (FRAC_BITS - 1));
        w.dir_re = rnd_re >>> FRAC_BITS;
        w.dir_im = rnd_im >>> FRAC_BITS;
      end
      default: ;
    endcase
    nre = PW'(p_rr) + PW'(p_ii);
    nim = PW'(p_ri) - PW'(p_ir);
    w.neg_re = nre[PW-1];
    w.neg_im = nim[PW-1];
    mag_re = NW'(nre[PW-1] ? -nre : nre);
    mag_im = NW'(nim[PW-1] ? -nim : nim);
    w.den = NW'(den_s);
    w.dz  = (den_s == '0);
    // scaled magnitude plus half divisor; quotient bits come out of the chain
    w.rem_re = (mag_re << FRAC_BITS) + (NW'(den_s) >> 1);
    w.rem_im = (mag_im << FRAC_BITS) + (NW'(den_s) >> 1);
    w.rs = (PW+1)'(PW'(p_rr) + PW'(p_ii));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.vld <= 1'b0;
    end else begin
      word_out.vld <= w.vld;
    end
    word_out.op     <= w.op;
    word_out.dz     <= w.dz;
    word_out.neg_re <= w.neg_re;
    word_out.neg_im <= w.neg_im;
    word_out.rem_re <= w.rem_re;
    word_out.rem_im <= w.rem_im;
    word_out.den    <= w.den;
    word_out.q_re   <= '0;
    word_out.q_im   <= '0;
    word_out.rs     <= w.rs;
    word_out.rr     <= '0;
    word_out.dir_re <= w.dir_re;
    word_out.dir_im <= w.dir_im;
  end

endmodule

@@ hdl/cau_cell.sv @@
module cau_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [4:0]           pos,
  input  cau_pkg::chain_t      word_in,
  output cau_pkg::chain_t      word_out
);
  import cau_pkg::*;

  chain_t w;
  logic [NW-1:0] dsh_re;
  logic [PW+RW:0] trial;
  logic [RW-1:0] rt;
  logic [PW:0]   rsv;
  int            k;
  int            rb;

  // one restoring quotient bit per cell, and root bits where assigned
  always_comb begin
    w = word_in;
    k = QW - 1 - int'(pos);
    dsh_re = '0;
    if ((NW'(word_in.den) << k) >> k == NW'(word_in.den)) begin
      dsh_re = NW'(word_in.den) << k;
      if (word_in.rem_re >= dsh_re) begin
        w.rem_re = word_in.rem_re - dsh_re;
        w.q_re[k] = 1'b1;
      end
      if (word_in.rem_im >= dsh_re) begin
        w.rem_im = word_in.rem_im - dsh_re;
        w.q_im[k] = 1'b1;
      end
    end
    rt  = word_in.rr;
    rsv = word_in.rs;
    trial = '0;
    rb = 0;
    for (int j = 0; j < RPC; j++) begin
      rb = RW - 1 - (int'(pos) * RPC + j);
      if (rb >= 0) begin
        trial = ((PW+RW+1)'(rt) << (rb + 1)) + ((PW+RW+1)'(1) << (2 * rb));
        if (trial <= (PW+RW+1)'(rsv)) begin
          rsv = rsv - (PW+1)'(trial);
          rt[rb] = 1'b1;
        end
      end
    end
    w.rr = rt;
    w.rs = rsv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.vld <= 1'b0;
    end else begin
      word_out.vld <= w.vld;
    end
    word_out.op     <= w.op;
    word_out.dz     <= w.dz;
    word_out.neg_re <= w.neg_re;
    word_out.neg_im <= w.neg_im;
    word_out.rem_re <= w.rem_re;
    word_out.rem_im <= w.rem_im;
    word_out.den    <= w.den;
    word_out.q_re   <= w.q_re;
    word_out.q_im   <= w.q_im;
    word_out.rs     <= w.rs;
    word_out.rr     <= w.rr;
    word_out.dir_re <= w.dir_re;
    word_out.dir_im <= w.dir_im;
  end

endmodule

@@ hdl/cau_back.sv @@
module cau_back (
  input  logic                clk,
  input  logic                rst,
  input  cau_pkg::chain_t     word_in,
  output logic                done,
  output cau_pkg::out_word_t  result
);
  import cau_pkg::*;

  out_word_t r;
  logic ov_re, ov_im;
  logic signed [NW:0] vre, vim;

  always_comb begin
    r = '0;
    ov_re = 1'b0;
    ov_im = 1'b0;
    vre = '0;
    vim = '0;
    case (op_t'(word_in.op))
      OP_ADD, OP_SUB, OP_MUL: begin
        vre = (NW+1)'(word_in.dir_re);
        vim = (NW+1)'(word_in.dir_im);
        r.res_re = sat16(vre, ov_re);
        r.res_im = sat16(vim, ov_im);
      end
      OP_DIV: begin
        if (word_in.dz) begin
          r.divide_by_zero = 1'b1;
        end else begin
          vre = (NW+1)'(word_in.q_re);
          vim = (NW+1)'(word_in.q_im);
          if (word_in.neg_re) vre = -vre;
          if (word_in.neg_im) vim = -vim;
          r.res_re = sat16(vre, ov_re);
          r.res_im = sat16(vim, ov_im);
        end
      end
      OP_MAG: begin
        vre = (NW+1)'(word_in.rr) + (NW+1)'(word_in.rs > (PW+1)'(word_in.rr));
        r.res_re = sat16(vre, ov_re);
      end
      default: ;
    endcase
    r.overflow = ov_re | ov_im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= word_in.vld;
    end
    result <= r;
  end

endmodule

@@ hdl/complex_arithmetic_unit.sv @@
// Complex arithmetic unit: add, subtract, multiply, divide of two signed
// Q8.8 complex operands, or the magnitude of the first one.
// Input: drive cmd and raise start for one cycle; busy is always low, so
// a new word is taken in every cycle.
// Output: done pulses high for exactly one cycle with the result word on
// result. There is no way to hold a result back; the receiver must take it.
// Every operation takes the same path from the edge that takes a word to
// the edge that takes its result: two front stages form products and sums,
// one chain cell per quotient bit resolves the restoring divide and the
// square root, and one output stage rounds and saturates. Throughput is
// one word per cycle.
// Reset (rst, synchronous) clears all valid bits in the chain; words in
// flight are dropped and done stays low until new words arrive.
module complex_arithmetic_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cau_pkg::in_word_t  cmd,
  output logic               done,
  output cau_pkg::out_word_t result
);
  import cau_pkg::*;

  chain_t link [NCELL+1];

  assign busy = 1'b0;

  cau_front u_front (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (start & ~busy),
    .word_in (cmd),
    .word_out(link[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    cau_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .pos     (5'(g)),
      .word_in (link[g]),
      .word_out(link[g+1])
    );
  end

  cau_back u_back (
    .clk    (clk),
    .rst    (rst),
    .word_in(link[NCELL]),
    .done   (done),
    .result (result)
  );

endmodule

@@ hdl/cau_checker.sv @@
`include "assert_macros.svh"

module cau_checker (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input cau_pkg::out_word_t result,
  input logic               done
);
  import cau_pkg::*;

  `ASSERT_IMPL(a_busy_low, clk, rst, 1'b1, !busy, "busy raised")
  `ASSERT_IMPL(a_dz_zero, clk, rst, done && result.divide_by_zero,
    result.res_re == 0 && result.res_im == 0 && !result.overflow, "dz result not zero")
  `ASSERT_IMPL(a_ovf_sat, clk, rst, done && result.overflow,
    result.res_re == 16'sh7fff || result.res_re == -16'sh8000 ||
    result.res_im == 16'sh7fff || result.res_im == -16'sh8000, "overflow without saturation")
  `ASSERT_NEXT(a_no_done_after_rst, clk, 1'b0, rst, !done, "done right after reset")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk   (clk),
  .rst   (rst),
  .busy  (busy),
  .result(result),
  .done  (done)
);

@@ tb/sv/complex_arithmetic_unit_test.sv @@
module complex_arithmetic_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  localparam int LATENCY = 3 + NCELL;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 1900;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_word_t cmd = '0;
  logic done;
  out_word_t result;

  complex_arithmetic_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  always #2 clk = ~clk;

  out_word_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int idle_pct = 0;

  typedef struct {
    in_word_t w;
    bit has_exp;
    out_word_t exp_w;
  } stim_row_t;

  stim_row_t stim_table[$];

  task automatic report_mismatch(input string what, input out_word_t got,
                                 input out_word_t want);
    errors++;
    $display("mismatch %s: got re=%0d im=%0d ov=%0b dz=%0b want re=%0d im=%0d ov=%0b dz=%0b",
             what, got.res_re, got.res_im, got.overflow, got.divide_by_zero,
             want.res_re, want.res_im, want.overflow, want.divide_by_zero);
  endtask

  function automatic longint clamp16(input longint v, inout bit ovf);
    if (v > 32767) begin
      ovf = 1;
      return 32767;
    end
    if (v < -32768) begin
      ovf = 1;
      return -32768;
    end
    return v;
  endfunction

  function automatic longint shift_round(input longint v);
    // floor after adding half an LSB; >>> on longint is arithmetic
    longint r;
    r = v + (longint'(1) << (FRAC_BITS - 1));
    return r >>> FRAC_BITS;
  endfunction

  function automatic longint scaled_quotient(input longint num, input longint den);
    longint unsigned mag, q;
    mag = (num < 0) ? -num : num;
    q = ((mag << FRAC_BITS) + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint rounded_root(input longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 40;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (s > r) r++;
    return longint'(r);
  endfunction

  function automatic out_word_t compute_result(input in_word_t w);
    longint ar, ai, br, bi, re, im, den;
    bit ovf, dz;
    out_word_t o;
    ar = w.a_re; ai = w.a_im; br = w.b_re; bi = w.b_im;
    re = 0; im = 0; ovf = 0; dz = 0;
    case (w.operation)
      OP_ADD: begin
        re = clamp16(ar + br, ovf);
        im = clamp16(ai + bi, ovf);
      end
      OP_SUB: begin
        re = clamp16(ar - br, ovf);
        im = clamp16(ai - bi, ovf);
      end
      OP_MUL: begin
        re = clamp16(shift_round(ar * br - ai * bi), ovf);
        im = clamp16(shift_round(ar * bi + ai * br), ovf);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) dz = 1;
        else begin
          re = clamp16(scaled_quotient(ar * br + ai * bi, den), ovf);
          im = clamp16(scaled_quotient(ai * br - ar * bi, den), ovf);
        end
      end
      OP_MAG: re = clamp16(rounded_root(ar * ar + ai * ai), ovf);
      default: ;
    endcase
    o.res_re = re[15:0];
    o.res_im = im[15:0];
    o.overflow = ovf;
    o.divide_by_zero = dz;
    return o;
  endfunction

  function automatic in_word_t mk(input logic [2:0] op, input int ar, input int ai,
                                  input int br, input int bi);
    in_word_t w;
    w.operation = op;
    w.a_re = ar[15:0]; w.a_im = ai[15:0]; w.b_re = br[15:0]; w.b_im = bi[15:0];
    return w;
  endfunction

  task automatic add_row(input in_word_t w, input bit has_exp, input int re,
                         input int im, input bit ov, input bit dz);
    stim_row_t r;
    r.w = w;
    r.has_exp = has_exp;
    r.exp_w.res_re = re[15:0];
    r.exp_w.res_im = im[15:0];
    r.exp_w.overflow = ov;
    r.exp_w.divide_by_zero = dz;
    stim_table.push_back(r);
  endtask

  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return 16'(int'($urandom_range(0, 1024)) - 512);
      3: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // driver: one word per accepted cycle, gaps per idle_pct
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(compute_result(w));
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", result, '0);
      end else begin
        out_word_t want;
        want = expected_q.pop_front();
        if (result.res_re !== want.res_re) report_mismatch("res_re", result, want);
        if (result.res_im !== want.res_im) report_mismatch("res_im", result, want);
        if (result.overflow !== want.overflow) report_mismatch("overflow", result, want);
        if (result.divide_by_zero !== want.divide_by_zero)
          report_mismatch("divide_by_zero", result, want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    add_row(mk(OP_ADD, 32767, -32768, 1, -1), 1, 32767, -32768, 1, 0);
    add_row(mk(OP_ADD, 0, 0, 0, 0), 1, 0, 0, 0, 0);
    add_row(mk(OP_SUB, -32768, 32767, 1, -1), 1, -32768, 32767, 1, 0);
    add_row(mk(OP_SUB, 32767, 32767, 32767, 32767), 1, 0, 0, 0, 0);
    add_row(mk(OP_MUL, 256, 0, 256, 0), 1, 256, 0, 0, 0);
    add_row(mk(OP_MUL, 32767, 32767, 32767, -32768), 0, 0, 0, 0, 0);
    add_row(mk(OP_MUL, -32768, -32768, -32768, -32768), 0, 0, 0, 0, 0);
    add_row(mk(OP_MUL, 1, 0, 128, 0), 0, 0, 0, 0, 0);
    add_row(mk(OP_MUL, -1, 0, 128, 0), 0, 0, 0, 0, 0);
    add_row(mk(OP_DIV, 256, 256, 0, 0), 1, 0, 0, 0, 1);
    add_row(mk(OP_DIV, -32768, 32767, 0, 0), 1, 0, 0, 0, 1);
    add_row(mk(OP_DIV, 32767, -32768, 1, 0), 0, 0, 0, 0, 0);
    add_row(mk(OP_DIV, 256, 0, 512, 0), 1, 128, 0, 0, 0);
    add_row(mk(OP_DIV, -32768, -32768, 32767, -32768), 0, 0, 0, 0, 0);
    add_row(mk(OP_DIV, 3, -5, -7, 2), 0, 0, 0, 0, 0);
    add_row(mk(OP_MAG, 768, 1024, 5, 5), 1, 1280, 0, 0, 0);
    add_row(mk(OP_MAG, -32768, -32768, 0, 0), 1, 32767, 0, 1, 0);
    add_row(mk(OP_MAG, 0, 0, 0, 0), 1, 0, 0, 0, 0);
    add_row(mk(OP_MAG, 1, 1, 0, 0), 0, 0, 0, 0, 0);
    add_row(mk(3'd5, 100, 100, 100, 100), 1, 0, 0, 0, 0);
    add_row(mk(3'd6, -1, -1, -1, -1), 1, 0, 0, 0, 0);
    add_row(mk(3'd7, 32767, -32768, 32767, -32768), 1, 0, 0, 0, 0);

    foreach (stim_table[i]) begin
      if (stim_table[i].has_exp && compute_result(stim_table[i].w) != stim_table[i].exp_w)
        report_mismatch("table row", compute_result(stim_table[i].w),
                        stim_table[i].exp_w);
      send_word(stim_table[i].w);
    end

    for (n = 0; n < N_RANDOM; n++) begin
      // phases: none, sender sparse, none, sender with rare gaps (receiver cannot stall)
      case (n * 4 / N_RANDOM)
        0: idle_pct = 0;
        1: idle_pct = 73;
        2: idle_pct = 0;
        default: idle_pct = 8;
      endcase
      w.operation = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
      w.a_re = rand_field();
      w.a_im = rand_field();
      w.b_re = rand_field();
      w.b_im = rand_field();
      if (w.operation == OP_DIV && $urandom_range(0, 9) == 0) begin
        w.b_re = '0;
        w.b_im = '0;
      end
      send_word(w);
    end
    start <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/cau_pkg.sv
hdl/cau_front.sv
hdl/cau_cell.sv
hdl/cau_back.sv
hdl/complex_arithmetic_unit.sv
hdl/cau_checker.sv
tb/sv/complex_arithmetic_unit_test.sv
